[sv/gefk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gefk_pkg: shared types, constants and arithmetic helpers
// Q16.16 constants, table of 2^-(j/16), saturating helpers for the gated FFN.
// ----------------------------------------------------------------------------
package gefk_pkg;

	localparam int HID_MAX = 64;
	localparam int INT_MAX = 256;
	localparam int HID_W   = 6;
	localparam int INT_W   = 8;
	localparam int WMEM_AW = HID_W + INT_W;
	localparam int WMEM_D  = HID_MAX * INT_MAX;

	localparam logic [1:0] OP_GATE  = 2'd0;
	localparam logic [1:0] OP_UP    = 2'd1;
	localparam logic [1:0] OP_DOWN  = 2'd2;
	localparam logic [1:0] OP_TOKEN = 2'd3;

	localparam logic [1:0] CFG_MODE  = 2'd0;
	localparam logic [1:0] CFG_HID   = 2'd1;
	localparam logic [1:0] CFG_INTER = 2'd2;

	localparam logic [1:0] MODE_GELU_ERF  = 2'd1;
	localparam logic [1:0] MODE_GELU_TANH = 2'd2;

	localparam logic signed [33:0] ONE_Q     = 34'sd65536;
	localparam logic signed [33:0] LOG2E_Q   = 34'sd94549;
	localparam logic signed [33:0] INVSQ2_Q  = 34'sd46341;
	localparam logic signed [33:0] GELU_K_Q  = 34'sd52290;
	localparam logic signed [33:0] GELU_C3_Q = 34'sd2930;
	localparam logic signed [33:0] AS_P      = 34'sd21469;
	localparam logic signed [33:0] AS_A1     = 34'sd16701;
	localparam logic signed [33:0] AS_A2     = -34'sd18645;
	localparam logic signed [33:0] AS_A3     = 34'sd93154;
	localparam logic signed [33:0] AS_A4     = -34'sd95234;
	localparam logic signed [33:0] AS_A5     = 34'sd69560;
	localparam logic signed [33:0] LIM6_Q    = 34'sd393216;
	localparam logic signed [33:0] LIM16_Q   = 34'sd1048576;
	localparam logic signed [33:0] LIM24_Q   = 34'sd1572864;
	localparam logic signed [33:0] LIM40_Q   = 34'sd2621440;

	typedef logic signed [33:0] aword_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [7:0]         row_index;
		logic [7:0]         column_index;
		logic signed [31:0] value;
		logic [15:0]        token_id;
		logic signed [31:0] route_weight;
		logic               last_element;
	} req_t;

	typedef struct packed {
		logic [15:0]        out_token;
		logic [5:0]         hidden_position;
		logic signed [31:0] contribution;
		logic               last_result;
	} rsp_t;

	typedef struct packed {
		logic               start;
		logic [1:0]         mode;
		logic signed [31:0] g;
		logic signed [31:0] u;
	} act_req_t;

	function automatic logic [16:0] pow2_tab(input logic [4:0] i);
		logic [16:0] v;
		case (i)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32_w(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// round half up by 16 with saturating add, then clamp to 32 bits
	function automatic logic signed [31:0] fin_q16(input logic signed [63:0] acc);
		logic signed [63:0] s;
		logic signed [63:0] t;
		s = sat_add64(acc, 64'sd32768);
		t = s >>> 16;
		return sat32_w({{4{t[63]}}, t});
	endfunction

endpackage
`default_nettype wire

[sv/gefk_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gefk_cell: one slot of the rotating token ring
// Takes its neighbor's element each cycle, or a freshly written element.
// ----------------------------------------------------------------------------
module gefk_cell (
	input  wire logic               clk,
	input  wire logic signed [31:0] nbr,
	input  wire logic               load,
	input  wire logic signed [31:0] wdata,
	output logic signed [31:0]      q
);
	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= load ? wdata : nbr;
	end

	assign q = data_q;
endmodule
`default_nettype wire

[sv/gefk_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gefk_div: serial reciprocal divider
// Computes (2^32 + d/2) / d one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gefk_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [17:0] den,
	output logic             done,
	output logic [16:0]      quo
);
	localparam logic [5:0] DIV_STEPS = 6'd33;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] num_q;
	logic [17:0] rem_q;
	logic [17:0] den_q;
	logic [18:0] rem_n;
	logic        qbit;
	logic [18:0] rem_d;

	always_comb begin
		rem_n = {rem_q, num_q[32]};
		qbit  = rem_n >= {1'b0, den_q};
		rem_d = qbit ? rem_n - {1'b0, den_q} : rem_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {1'b1, 32'd0} + {15'd0, den[17:1]};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], qbit};
			rem_q <= rem_d[17:0];
		end
	end

	assign done = done_q;
	assign quo  = num_q[16:0];
endmodule
`default_nettype wire

[sv/gefk_act.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gefk_act: activation and gating sequencer
// SiLU / GELU-erf / GELU-tanh of the gate value times the up value, built on
// one shared registered multiplier and the serial divider.
// ----------------------------------------------------------------------------
module gefk_act (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gefk_pkg::act_req_t   areq,
	output logic                      done,
	output logic signed [31:0]        result
);
	import gefk_pkg::*;

	localparam logic [5:0] A_IDLE = 6'd0;
	localparam logic [5:0] A_START = 6'd1;
	localparam logic [5:0] A_E1 = 6'd2;
	localparam logic [5:0] A_E2 = 6'd3;
	localparam logic [5:0] A_E3 = 6'd4;
	localparam logic [5:0] A_E4 = 6'd5;
	localparam logic [5:0] A_E5 = 6'd6;
	localparam logic [5:0] A_E6 = 6'd7;
	localparam logic [5:0] A_E7 = 6'd8;
	localparam logic [5:0] A_E8 = 6'd9;
	localparam logic [5:0] A_ERFR = 6'd10;
	localparam logic [5:0] A_E9A = 6'd11;
	localparam logic [5:0] A_E9 = 6'd12;
	localparam logic [5:0] A_FIN = 6'd13;
	localparam logic [5:0] A_FIN2 = 6'd14;
	localparam logic [5:0] A_MID = 6'd15;
	localparam logic [5:0] A_MID2 = 6'd16;
	localparam logic [5:0] A_T1 = 6'd17;
	localparam logic [5:0] A_T2 = 6'd18;
	localparam logic [5:0] A_T3 = 6'd19;
	localparam logic [5:0] A_T4 = 6'd20;
	localparam logic [5:0] A_T5 = 6'd21;
	localparam logic [5:0] A_T6 = 6'd22;
	localparam logic [5:0] A_T7 = 6'd23;
	localparam logic [5:0] A_TH = 6'd24;
	localparam logic [5:0] A_SL = 6'd25;
	localparam logic [5:0] A_SL2 = 6'd26;
	localparam logic [5:0] A_SG0 = 6'd27;
	localparam logic [5:0] A_SGR = 6'd28;
	localparam logic [5:0] A_SG1 = 6'd29;
	localparam logic [5:0] A_X0 = 6'd30;
	localparam logic [5:0] A_X1 = 6'd31;
	localparam logic [5:0] A_X2 = 6'd32;

	logic [5:0] st_q, eret_q, sret_q;
	logic [1:0] mode_q;
	aword_t     g_q, u_q, z_q, a_q, t_q, p_q, r_q, s_q, sx_q, ey_q, ex_q, act_q;
	logic [16:0] xv_q;
	logic [4:0]  xk_q;
	logic [2:0]  cnt_q;
	logic signed [67:0] mp_q;
	logic signed [31:0] res_q;
	logic        done_q;

	aword_t ma, mb;
	logic signed [67:0] r16_f, r17_f;
	aword_t r16_w, r17_w, r_clamp, p_add;
	logic        div_start, div_done;
	logic [17:0] div_den;
	logic [16:0] div_quo;

	// exp table interpolation
	logic [3:0]  x_idx;
	logic [11:0] x_fr;
	logic [16:0] x_t0, x_t1, x_diff, x_v;
	logic [23:0] x_prod, x_rp;
	logic [17:0] x_sh;

	gefk_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		r16_f = (mp_q + 68'sd32768) >>> 16;
		r17_f = (mp_q + 68'sd65536) >>> 17;
		r16_w = r16_f[33:0];
		r17_w = r17_f[33:0];
		r_clamp = ONE_Q - r16_w;
		if (r_clamp < 34'sd0) begin
			r_clamp = 34'sd0;
		end else if (r_clamp > ONE_Q) begin
			r_clamp = ONE_Q;
		end
		case (cnt_q)
			3'd0:    p_add = AS_A4;
			3'd1:    p_add = AS_A3;
			3'd2:    p_add = AS_A2;
			3'd3:    p_add = AS_A1;
			default: p_add = 34'sd0;
		endcase
		x_idx  = r16_w[15:12];
		x_fr   = r16_w[11:0];
		x_t0   = pow2_tab({1'b0, x_idx});
		x_t1   = pow2_tab({1'b0, x_idx} + 5'd1);
		x_diff = x_t0 - x_t1;
		x_prod = {12'd0, x_diff[11:0]} * {12'd0, x_fr};
		x_rp   = (x_prod + 24'd2048) >> 12;
		x_v    = x_t0 - {5'd0, x_rp[11:0]};
		x_sh   = ({1'b0, xv_q} + (18'd1 << (xk_q - 5'd1))) >> xk_q;
	end

	always_comb begin
		ma = g_q;
		mb = g_q;
		unique case (st_q)
			A_START: mb = (mode_q == MODE_GELU_ERF) ? INVSQ2_Q : g_q;
			A_E2: begin ma = AS_P; mb = a_q; end
			A_E5: begin ma = p_q; mb = t_q; end
			A_E7: begin ma = a_q; mb = a_q; end
			A_ERFR: begin ma = p_q; mb = ex_q; end
			A_FIN: mb = ONE_Q + t_q;
			A_MID: begin ma = act_q; mb = u_q; end
			A_T2: begin ma = a_q; mb = g_q; end
			A_T4: begin ma = GELU_C3_Q; mb = a_q; end
			A_T6: begin ma = GELU_K_Q; mb = a_q; end
			A_SL: mb = s_q;
			A_X0: begin ma = ey_q; mb = LOG2E_Q; end
			default: begin ma = g_q; mb = g_q; end
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		div_den   = 18'(ONE_Q + ex_q);
		if (st_q == A_E3) begin
			div_start = 1'b1;
			div_den   = 18'(ONE_Q + r16_w);
		end else if (st_q == A_SGR) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mp_q <= ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			eret_q <= A_IDLE;
			sret_q <= A_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: if (areq.start) st_q <= A_START;
				A_START: begin
					if (mode_q == MODE_GELU_ERF) begin
						st_q <= A_E1;
					end else if (mode_q == MODE_GELU_TANH) begin
						if (g_q > LIM16_Q || g_q < -LIM16_Q) st_q <= A_FIN;
						else st_q <= A_T1;
					end else if (g_q > LIM40_Q || g_q < -LIM40_Q) begin
						st_q <= A_MID;
					end else begin
						sret_q <= A_SL;
						st_q   <= A_SG0;
					end
				end
				A_E1: st_q <= A_E2;
				A_E2: st_q <= (a_q >= LIM6_Q) ? A_E9 : A_E3;
				A_E3: st_q <= A_E4;
				A_E4: if (div_done) begin
					cnt_q <= '0;
					st_q  <= A_E5;
				end
				A_E5: st_q <= A_E6;
				A_E6: begin
					cnt_q <= cnt_q + 3'd1;
					st_q  <= (cnt_q == 3'd4) ? A_E7 : A_E5;
				end
				A_E7: st_q <= A_E8;
				A_E8: begin
					eret_q <= A_ERFR;
					st_q   <= A_X0;
				end
				A_ERFR: st_q <= A_E9A;
				A_E9A: st_q <= A_E9;
				A_E9: st_q <= A_FIN;
				A_FIN: st_q <= A_FIN2;
				A_FIN2: st_q <= A_MID;
				A_MID: st_q <= A_MID2;
				A_MID2: begin
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				A_T1: st_q <= A_T2;
				A_T2: st_q <= A_T3;
				A_T3: st_q <= A_T4;
				A_T4: st_q <= A_T5;
				A_T5: st_q <= A_T6;
				A_T6: st_q <= A_T7;
				A_T7: begin
					sret_q <= A_TH;
					st_q   <= A_SG0;
				end
				A_TH: st_q <= A_FIN;
				A_SL: st_q <= A_SL2;
				A_SL2: st_q <= A_MID;
				A_SG0: begin
					eret_q <= A_SGR;
					st_q   <= A_X0;
				end
				A_SGR: st_q <= A_SG1;
				A_SG1: if (div_done) st_q <= sret_q;
				A_X0: st_q <= (ey_q >= LIM24_Q) ? eret_q : A_X1;
				A_X1: st_q <= (r16_w[33:16] >= 18'd17) ? eret_q : A_X2;
				A_X2: st_q <= eret_q;
				default: st_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: if (areq.start) begin
				mode_q <= areq.mode;
				g_q    <= 34'(areq.g);
				u_q    <= 34'(areq.u);
			end
			A_START: begin
				if (mode_q == MODE_GELU_TANH) begin
					t_q <= (g_q > LIM16_Q) ? ONE_Q : -ONE_Q;
				end
				act_q <= (g_q > LIM40_Q) ? g_q : 34'sd0;
				sx_q  <= g_q;
			end
			A_E1: begin
				z_q <= r16_w;
				a_q <= (r16_w < 34'sd0) ? -r16_w : r16_w;
			end
			A_E2: r_q <= ONE_Q;
			A_E4: begin
				t_q <= {17'd0, div_quo};
				p_q <= AS_A5;
			end
			A_E6: p_q <= r16_w + p_add;
			A_E8: ey_q <= r16_w;
			A_E9A: r_q <= r_clamp;
			A_E9: t_q <= (z_q < 34'sd0) ? -r_q : r_q;
			A_FIN2: act_q <= r17_w;
			A_MID2: res_q <= sat32_w(r16_f);
			A_T1: a_q <= r16_w;
			A_T3: a_q <= r16_w;
			A_T5: a_q <= g_q + r16_w;
			A_T7: sx_q <= r16_w <<< 1;
			A_TH: t_q <= (s_q <<< 1) - ONE_Q;
			A_SL2: act_q <= r16_w;
			A_SG0: ey_q <= (sx_q < 34'sd0) ? -sx_q : sx_q;
			A_SG1: s_q <= (sx_q >= 34'sd0) ? {17'd0, div_quo} : ONE_Q - {17'd0, div_quo};
			A_X0: ex_q <= 34'sd0;
			A_X1: begin
				ex_q <= 34'sd0;
				xv_q <= x_v;
				xk_q <= r16_w[20:16];
			end
			A_X2: ex_q <= (xk_q == 5'd0) ? {17'd0, xv_q} : {16'd0, x_sh};
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;
endmodule
`default_nettype wire

[sv/gated_expert_ffn_kernel.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gated_expert_ffn_kernel: one gated expert feed-forward unit
// Weight loads, token elements, gate/up dot products, activation, down
// projection scaled by the route weight.
// ----------------------------------------------------------------------------
//  channel  | signals                         | moves
//  req      | req_valid, req_ready, req       | load or token element in
//  rsp      | rsp_valid, rsp_ready, rsp       | one contribution per hidden index
//  cfg      | cfg_we, cfg_index, cfg_data     | register write, no wait
//
// Loads and non-final token elements are taken without leaving idle. A final
// element runs the whole token: per intermediate row a wait for token-ring
// alignment, a MAC over the H ring elements, the pipeline drain and the
// activation (SiLU, erf GELU or tanh GELU); then per hidden index a MAC over
// the I intermediate values, a drain and the route scaling. req_ready is low meanwhile.
// A stalled rsp holds the down phase before the next hidden index.
// Reset clears control only; stores hold garbage until written.
// ----------------------------------------------------------------------------
module gated_expert_ffn_kernel (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire gefk_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output gefk_pkg::rsp_t       rsp,
	input  wire logic            cfg_we,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [8:0]      cfg_data
);
	import gefk_pkg::*;

	localparam logic [3:0] M_IDLE   = 4'd0;
	localparam logic [3:0] M_GWAIT  = 4'd1;
	localparam logic [3:0] M_GRUN   = 4'd2;
	localparam logic [3:0] M_GDRAIN = 4'd3;
	localparam logic [3:0] M_GACT   = 4'd4;
	localparam logic [3:0] M_DWAIT  = 4'd5;
	localparam logic [3:0] M_DRUN   = 4'd6;
	localparam logic [3:0] M_DDRAIN = 4'd7;
	localparam logic [3:0] M_DFIN1  = 4'd8;
	localparam logic [3:0] M_DFIN2  = 4'd9;
	localparam logic [3:0] M_DFIN3  = 4'd10;

	logic [3:0] st_q;
	logic [1:0] mode_q;
	logic [6:0] hid_q, hs_q, h_q;
	logic [8:0] inter_q, is_q, r_q, rc_q;
	logic [HID_W-1:0] rot_q;
	logic [15:0] tok_q;
	logic signed [31:0] route_q, dsum_q;
	logic signed [63:0] rp_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic acc_in;
	logic [6:0] hs_n;
	logic [8:0] is_n;

	// token ring
	logic signed [31:0] ring [HID_MAX];
	logic [HID_W-1:0] slot;
	logic tok_wr;

	// weight stores
	logic signed [31:0] gate_mem [WMEM_D];
	logic signed [31:0] up_mem [WMEM_D];
	logic signed [31:0] down_mem [WMEM_D];
	logic signed [31:0] mid_mem [INT_MAX];
	logic gate_we, up_we, down_we, mid_we;
	logic [WMEM_AW-1:0] gu_waddr, d_waddr, g_raddr, d_raddr;

	// MAC pipeline
	logic iss_v, iss_last, iss_ph;
	logic v_s1, last_s1, ph_s1, v_s2, last_s2, fin_s3;
	logic signed [31:0] x_s1, gate_rd_s1, up_rd_s1, down_rd_s1, mid_rd_s1;
	logic signed [31:0] opa, opb;
	logic signed [63:0] a_s2, b_s2, accg_q, accu_q;
	logic acc_clr;

	act_req_t areq;
	logic act_done;
	logic signed [31:0] act_res;

	assign acc_in = req_valid && req_ready;
	assign hs_n   = (hid_q > 7'd64) ? 7'd64 : hid_q;
	assign is_n   = (inter_q > 9'd256) ? 9'd256 : inter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 2'd0;
			hid_q   <= 7'd64;
			inter_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:  mode_q  <= cfg_data[1:0];
				CFG_HID:   hid_q   <= cfg_data[6:0];
				CFG_INTER: inter_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ring rotates every cycle; cell i holds element (i + rot) mod 64
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rot_q <= '0;
		else rot_q <= rot_q + HID_W'(1);
	end

	assign tok_wr = acc_in && req.opcode == OP_TOKEN && req.column_index[7:HID_W] == '0;
	assign slot   = req.column_index[HID_W-1:0] - rot_q - HID_W'(1);

	for (genvar i = 0; i < HID_MAX; i++) begin : g_ring
		gefk_cell u_cell (
			.clk   (clk),
			.nbr   (ring[(i + 1) % HID_MAX]),
			.load  (tok_wr && slot == HID_W'(i)),
			.wdata (req.value),
			.q     (ring[i])
		);
	end

	assign gate_we  = acc_in && req.opcode == OP_GATE && req.column_index[7:HID_W] == '0;
	assign up_we    = acc_in && req.opcode == OP_UP && req.column_index[7:HID_W] == '0;
	assign down_we  = acc_in && req.opcode == OP_DOWN && req.row_index[7:HID_W] == '0;
	assign gu_waddr = {req.row_index, req.column_index[HID_W-1:0]};
	assign d_waddr  = {req.row_index[HID_W-1:0], req.column_index};
	assign g_raddr  = {r_q[INT_W-1:0], rot_q};
	assign d_raddr  = {h_q[HID_W-1:0], rc_q[INT_W-1:0]};
	assign mid_we   = st_q == M_GACT && act_done;

	always_ff @(posedge clk) begin
		if (gate_we) gate_mem[gu_waddr] <= req.value;
		gate_rd_s1 <= gate_mem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (up_we) up_mem[gu_waddr] <= req.value;
		up_rd_s1 <= up_mem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (down_we) down_mem[d_waddr] <= req.value;
		down_rd_s1 <= down_mem[d_raddr];
	end

	always_ff @(posedge clk) begin
		if (mid_we) mid_mem[r_q[INT_W-1:0]] <= act_res;
		mid_rd_s1 <= mid_mem[rc_q[INT_W-1:0]];
	end

	// issue: gate phase walks the ring head, down phase walks rc_q
	always_comb begin
		iss_v    = 1'b0;
		iss_last = 1'b0;
		iss_ph   = 1'b0;
		if ((st_q == M_GWAIT && rot_q == '0) || st_q == M_GRUN) begin
			iss_v    = 1'b1;
			iss_last = {1'b0, rot_q} + 7'd1 == hs_q;
		end else if (st_q == M_DRUN) begin
			iss_v    = 1'b1;
			iss_ph   = 1'b1;
			iss_last = rc_q + 9'd1 == is_q;
		end
	end

	assign acc_clr = st_q == M_GWAIT || st_q == M_DWAIT;
	assign opa = ph_s1 ? down_rd_s1 : gate_rd_s1;
	assign opb = ph_s1 ? mid_rd_s1 : x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			fin_s3 <= 1'b0;
		end else begin
			v_s1   <= iss_v;
			v_s2   <= v_s1;
			fin_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= iss_last;
		ph_s1   <= iss_ph;
		x_s1    <= ring[0];
		last_s2 <= last_s1;
		a_s2    <= opa * opb;
		b_s2    <= up_rd_s1 * x_s1;
		if (acc_clr) begin
			accg_q <= '0;
			accu_q <= '0;
		end else if (v_s2) begin
			accg_q <= sat_add64(accg_q, a_s2);
			accu_q <= sat_add64(accu_q, b_s2);
		end
	end

	assign areq.start = st_q == M_GDRAIN && fin_s3;
	assign areq.mode  = mode_q;
	assign areq.g     = fin_q16(accg_q);
	assign areq.u     = fin_q16(accu_q);

	gefk_act u_act (
		.clk    (clk),
		.arst_n (arst_n),
		.areq   (areq),
		.done   (act_done),
		.result (act_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= M_IDLE;
			hs_q        <= '0;
			is_q        <= '0;
			h_q         <= '0;
			r_q         <= '0;
			rc_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (acc_in && req.opcode == OP_TOKEN && req.last_element) begin
						hs_q <= hs_n;
						is_q <= is_n;
						r_q  <= '0;
						h_q  <= '0;
						if (hs_n == '0) st_q <= M_IDLE;
						else if (is_n == '0) st_q <= M_DWAIT;
						else st_q <= M_GWAIT;
					end
				end
				M_GWAIT: if (rot_q == '0) st_q <= (hs_q == 7'd1) ? M_GDRAIN : M_GRUN;
				M_GRUN: if (iss_last) st_q <= M_GDRAIN;
				M_GDRAIN: if (fin_s3) st_q <= M_GACT;
				M_GACT: begin
					if (act_done) begin
						r_q <= r_q + 9'd1;
						st_q <= (r_q + 9'd1 == is_q) ? M_DWAIT : M_GWAIT;
					end
				end
				M_DWAIT: begin
					rc_q <= '0;
					if (!rsp_valid_q) st_q <= (is_q == '0) ? M_DFIN1 : M_DRUN;
				end
				M_DRUN: begin
					rc_q <= rc_q + 9'd1;
					if (iss_last) st_q <= M_DDRAIN;
				end
				M_DDRAIN: if (fin_s3) st_q <= M_DFIN1;
				M_DFIN1: st_q <= M_DFIN2;
				M_DFIN2: st_q <= M_DFIN3;
				M_DFIN3: begin
					rsp_valid_q <= 1'b1;
					h_q <= h_q + 7'd1;
					st_q <= (h_q + 7'd1 == hs_q) ? M_IDLE : M_DWAIT;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == M_IDLE && acc_in && req.opcode == OP_TOKEN && req.last_element) begin
			tok_q   <= req.token_id;
			route_q <= req.route_weight;
		end
		if (st_q == M_DFIN1) dsum_q <= fin_q16(accg_q);
		if (st_q == M_DFIN2) rp_q <= dsum_q * route_q;
		if (st_q == M_DFIN3) begin
			rsp_q.out_token       <= tok_q;
			rsp_q.hidden_position <= h_q[HID_W-1:0];
			rsp_q.contribution    <= fin_q16(rp_q);
			rsp_q.last_result     <= h_q + 7'd1 == hs_q;
		end
	end

	assign req_ready = st_q == M_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule
`default_nettype wire

[test/gefk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gefk_checker: scoreboard for the gated expert FFN
// Mirrors the weight stores, token elements and registers from observed
// transfers, computes each token's contributions and compares them in order.
// ----------------------------------------------------------------------------
module gefk_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire logic           req_ready,
	input  wire gefk_pkg::req_t req,
	input  wire logic           rsp_valid,
	input  wire logic           rsp_ready,
	input  wire gefk_pkg::rsp_t rsp,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [8:0]     cfg_data,
	output int                  mismatches,
	output int                  pending
);
	import gefk_pkg::*;

	localparam longint Q1 = 65536;

	int gate_w [256][64];
	int up_w [256][64];
	int down_w [64][256];
	int tok_vec [64];
	int mid_vec [256];
	logic [1:0] act_mode;
	logic [6:0] hid_cfg;
	logic [8:0] inter_cfg;
	rsp_t contrib_q[$];

	assign pending = contrib_q.size();

	function automatic longint qadd(input longint a, input longint b);
		if (b > 0 && a > 64'sh7fffffffffffffff - b) return 64'sh7fffffffffffffff;
		if (b < 0 && a < 64'sh8000000000000000 - b) return 64'sh8000000000000000;
		return a + b;
	endfunction

	function automatic longint rnd(input longint v, input int n);
		return qadd(v, longint'(1) << (n - 1)) >>> n;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint pow2n(input longint j);
		case (j)
			0: return 65536;  1: return 62757;  2: return 60097;  3: return 57549;
			4: return 55109;  5: return 52773;  6: return 50535;  7: return 48393;
			8: return 46341;  9: return 44376;  10: return 42495; 11: return 40693;
			12: return 38968; 13: return 37316; 14: return 35734; 15: return 34219;
			default: return 32768;
		endcase
	endfunction

	// e^-y, y >= 0, via 2^-(y*log2 e) with table interpolation
	function automatic longint exp_neg(input longint y);
		longint z, k, f, idx, fr, v;
		if (y >= 24 * Q1) return 0;
		z = rnd(y * 94549, 16);
		k = z >>> 16;
		if (k >= 17) return 0;
		f = z & 65535;
		idx = f >> 12;
		fr = f & 4095;
		v = pow2n(idx) - rnd((pow2n(idx) - pow2n(idx + 1)) * fr, 12);
		return (k != 0) ? rnd(v, int'(k)) : v;
	endfunction

	function automatic longint sigm(input longint x);
		longint ax, d, s;
		ax = (x >= 0) ? x : -x;
		d = Q1 + exp_neg(ax);
		s = ((longint'(1) << 32) + d / 2) / d;
		return (x >= 0) ? s : Q1 - s;
	endfunction

	function automatic longint erf_fx(input longint z);
		longint a, d, t, p, e, r;
		a = (z >= 0) ? z : -z;
		if (a >= 6 * Q1) begin
			r = Q1;
		end else begin
			d = Q1 + rnd(21469 * a, 16);
			t = ((longint'(1) << 32) + d / 2) / d;
			p = 69560;
			p = rnd(p * t, 16) - 95234;
			p = rnd(p * t, 16) + 93154;
			p = rnd(p * t, 16) - 18645;
			p = rnd(p * t, 16) + 16701;
			p = rnd(p * t, 16);
			e = exp_neg(rnd(a * a, 16));
			r = Q1 - rnd(p * e, 16);
			if (r < 0) r = 0;
			if (r > Q1) r = Q1;
		end
		return (z >= 0) ? r : -r;
	endfunction

	function automatic longint activate(input longint g);
		longint t, x2, x3, inner;
		if (act_mode == MODE_GELU_ERF) begin
			t = erf_fx(rnd(g * 46341, 16));
			return rnd(g * (Q1 + t), 17);
		end
		if (act_mode == MODE_GELU_TANH) begin
			if (g > 16 * Q1) begin
				t = Q1;
			end else if (g < -16 * Q1) begin
				t = -Q1;
			end else begin
				x2 = rnd(g * g, 16);
				x3 = rnd(x2 * g, 16);
				inner = rnd(52290 * (g + rnd(2930 * x3, 16)), 16);
				t = 2 * sigm(2 * inner) - Q1;
			end
			return rnd(g * (Q1 + t), 17);
		end
		if (g > 40 * Q1) return g;
		if (g < -40 * Q1) return 0;
		return rnd(g * sigm(g), 16);
	endfunction

	task automatic predict_token(input logic [15:0] tok, input logic signed [31:0] route);
		int hs, is;
		longint g, u, acc;
		rsp_t e;
		hs = (hid_cfg > 64) ? 64 : int'(hid_cfg);
		is = (inter_cfg > 256) ? 256 : int'(inter_cfg);
		for (int r = 0; r < is; r++) begin
			g = 0;
			u = 0;
			for (int h = 0; h < hs; h++) begin
				g = qadd(g, longint'(gate_w[r][h]) * longint'(tok_vec[h]));
				u = qadd(u, longint'(up_w[r][h]) * longint'(tok_vec[h]));
			end
			g = clamp32(rnd(g, 16));
			u = clamp32(rnd(u, 16));
			mid_vec[r] = int'(clamp32(rnd(activate(g) * u, 16)));
		end
		for (int h = 0; h < hs; h++) begin
			acc = 0;
			for (int r = 0; r < is; r++)
				acc = qadd(acc, longint'(down_w[h][r]) * longint'(mid_vec[r]));
			acc = clamp32(rnd(acc, 16));
			acc = clamp32(rnd(acc * longint'(route), 16));
			e.out_token = tok;
			e.hidden_position = h[5:0];
			e.contribution = acc[31:0];
			e.last_result = (h == hs - 1);
			contrib_q.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode <= 2'd0;
			hid_cfg <= 7'd64;
			inter_cfg <= 9'd256;
			mismatches <= 0;
			contrib_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE:  act_mode <= cfg_data[1:0];
					CFG_HID:   hid_cfg <= cfg_data[6:0];
					CFG_INTER: inter_cfg <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				case (req.opcode)
					OP_GATE: if (req.column_index < 64)
						gate_w[req.row_index][req.column_index] = req.value;
					OP_UP: if (req.column_index < 64)
						up_w[req.row_index][req.column_index] = req.value;
					OP_DOWN: if (req.row_index < 64)
						down_w[req.row_index][req.column_index] = req.value;
					default: begin
						if (req.column_index < 64) tok_vec[req.column_index] = req.value;
						if (req.last_element) predict_token(req.token_id, req.route_weight);
					end
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (contrib_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected transfer: tok %0d pos %0d val %0d",
							rsp.out_token, rsp.hidden_position, rsp.contribution);
					mismatches <= mismatches + 1;
				end else begin
					if (rsp !== contrib_q[0]) begin
						if (mismatches < 10)
							$display("mismatch: exp tok %0d pos %0d val %0d last %0b, got tok %0d pos %0d val %0d last %0b",
								contrib_q[0].out_token, contrib_q[0].hidden_position,
								contrib_q[0].contribution, contrib_q[0].last_result,
								rsp.out_token, rsp.hidden_position, rsp.contribution,
								rsp.last_result);
						mismatches <= mismatches + 1;
					end
					void'(contrib_q.pop_front());
				end
			end
		end
	end

endmodule

[test/gated_expert_ffn_kernel_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_expert_ffn_kernel_tb: stimulus and verdict for the gated expert FFN
// Preloads the store region that tokens read, runs directed corner tokens and
// random phases of loads and tokens under several register settings.
// ----------------------------------------------------------------------------
module gated_expert_ffn_kernel_tb;
	import gefk_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	int         mismatches;
	int         pending;
	logic       calm;
	logic       hold_ask;
	logic       hold_done;
	int         hold_left;
	int         sent;

	gated_expert_ffn_kernel u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	gefk_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#60000000;
		$display("Mismatches found");
		$finish;
	end

	// receiver: random stalls unless calm, plus one long hold-off at the first result once asked for
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ask && !hold_done && rsp_valid) begin
			rsp_ready <= 1'b0;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else begin
			rsp_ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	function automatic req_t mk(input logic [1:0] op, input logic [7:0] row,
		input logic [7:0] col, input logic [31:0] val, input logic [15:0] tok,
		input logic [31:0] route, input logic last);
		req_t t;
		t.opcode = op;
		t.row_index = row;
		t.column_index = col;
		t.value = val;
		t.token_id = tok;
		t.route_weight = route;
		t.last_element = last;
		return t;
	endfunction

	function automatic logic [31:0] rnd_q();
		int r;
		r = $urandom_range(99);
		if (r < 70) return 32'($urandom_range(262143)) - 32'd131072;
		if (r < 85) return $urandom;
		return 32'($urandom_range(33554431)) - 32'd16777216;
	endfunction

	task automatic offer(input req_t t);
		while (!calm && $urandom_range(99) < 17) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= t;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	// block idle: results drained and an ignored load got through
	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		offer(mk(OP_GATE, 8'd0, 8'd255, 32'd0, 16'd0, 32'd0, 1'b0));
		req_valid <= 1'b0;
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(input logic [1:0] m, input logic [8:0] h, input logic [8:0] i);
		settle();
		set_reg(CFG_MODE, {7'd0, m});
		set_reg(CFG_HID, h);
		set_reg(CFG_INTER, i);
	endtask

	initial begin
		int hs, is, n, k, pick;
		logic [1:0] op;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		calm = 1'b0;
		hold_ask = 1'b0;
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the region that tokens read: 8 rows by 4 hidden positions
		for (int r = 0; r < 8; r++)
			for (int h = 0; h < 4; h++) begin
				offer(mk(OP_GATE, r[7:0], h[7:0], 32'($urandom_range(262143)) - 32'd131072,
					16'd0, 32'd0, 1'b0));
				offer(mk(OP_UP, r[7:0], h[7:0], 32'($urandom_range(262143)) - 32'd131072,
					16'd0, 32'd0, 1'b0));
				offer(mk(OP_DOWN, h[7:0], r[7:0], 32'($urandom_range(262143)) - 32'd131072,
					16'd0, 32'd0, 1'b0));
			end
		for (int h = 0; h < 4; h++)
			offer(mk(OP_TOKEN, 8'd0, h[7:0], 32'($urandom_range(262143)) - 32'd131072,
				16'd0, 32'd0, 1'b0));

		// extreme elements and route weights
		setup(2'd0, 9'd2, 9'd2);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h7fffffff, 16'hffff, 32'h7fffffff, 1'b0));
		offer(mk(OP_TOKEN, 8'd0, 8'd1, 32'h80000000, 16'hffff, 32'h7fffffff, 1'b1));
		offer(mk(OP_TOKEN, 8'd0, 8'd1, 32'h80000000, 16'h0000, 32'h80000000, 1'b1));
		// activation clamps: one element of 1.0 drives the gate straight
		setup(2'd0, 9'd1, 9'd1);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd1, 32'h00010000, 1'b0));
		offer(mk(OP_UP, 8'd0, 8'd0, 32'h00010000, 16'd1, 32'd0, 1'b0));
		offer(mk(OP_DOWN, 8'd0, 8'd0, 32'h00010000, 16'd1, 32'd0, 1'b0));
		offer(mk(OP_GATE, 8'd0, 8'd0, 32'h00320000, 16'd1, 32'd0, 1'b1));
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd2, 32'h00010000, 1'b1));
		offer(mk(OP_GATE, 8'd0, 8'd0, 32'hffce0000, 16'd1, 32'd0, 1'b0));
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd3, 32'h00010000, 1'b1));
		setup(2'd2, 9'd1, 9'd1);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd4, 32'h00010000, 1'b1));
		offer(mk(OP_GATE, 8'd0, 8'd0, 32'h00140000, 16'd1, 32'd0, 1'b0));
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd5, 32'h00010000, 1'b1));
		setup(2'd1, 9'd1, 9'd1);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd6, 32'h00010000, 1'b1));
		offer(mk(OP_GATE, 8'd0, 8'd0, 32'hfff60000, 16'd1, 32'd0, 1'b0));
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd7, 32'h00010000, 1'b1));
		// a mark on a weight load starts nothing; out-of-range loads are dropped
		offer(mk(OP_DOWN, 8'd200, 8'd0, 32'h12345678, 16'd8, 32'd0, 1'b1));
		offer(mk(OP_GATE, 8'd0, 8'd64, 32'h12345678, 16'd8, 32'd0, 1'b1));
		offer(mk(OP_TOKEN, 8'd0, 8'd99, 32'h12345678, 16'd9, 32'h00008000, 1'b1));
		// zero hidden size gives nothing, zero intermediate size gives zeros
		setup(2'd3, 9'd0, 9'd1);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd10, 32'h00010000, 1'b1));
		setup(2'd0, 9'd3, 9'd0);
		offer(mk(OP_TOKEN, 8'd0, 8'd0, 32'h00010000, 16'd11, 32'h00010000, 1'b1));
		// oversized hidden size acts as the full ring: 64 zero contributions
		setup(2'd3, 9'd127, 9'd0);
		offer(mk(OP_TOKEN, 8'd0, 8'd5, rnd_q(), 16'd12, 32'h00010000, 1'b1));

		// random phases: well-formed token sequences with noise mixed in
		k = 0;
		while (sent < 270) begin
			k++;
			hs = (k == 5) ? 4 : $urandom_range(1, 4);
			is = $urandom_range(0, 8);
			setup(2'($urandom_range(3)), 9'(hs), 9'(is));
			calm <= (k >= 8 && k < 14);
			if (k == 5) hold_ask <= 1'b1;
			n = $urandom_range(4, 10);
			for (int j = 0; j < n; j++) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					op = 2'($urandom_range(2));
					if (op == OP_DOWN)
						offer(mk(op, 8'($urandom_range(hs - 1)),
							8'($urandom_range(is > 0 ? is - 1 : 0)), rnd_q(),
							16'($urandom), $urandom, 1'($urandom)));
					else
						offer(mk(op, 8'($urandom_range(is > 0 ? is - 1 : 0)),
							8'($urandom_range(hs - 1)), rnd_q(),
							16'($urandom), $urandom, 1'($urandom)));
				end else if (pick < 75) begin
					offer(mk(OP_TOKEN, 8'($urandom), 8'($urandom_range(hs - 1)), rnd_q(),
						16'($urandom), $urandom, 1'b0));
				end else begin
					offer(mk(2'($urandom), 8'($urandom), 8'($urandom), $urandom,
						16'($urandom), $urandom, ($urandom_range(7) == 0)));
				end
			end
			offer(mk(OP_TOKEN, 8'($urandom), 8'($urandom_range(hs - 1)),
				rnd_q(), 16'($urandom), rnd_q(), 1'b1));
			// keep offering loads while results may still be stalled
			repeat ((k == 5) ? 2 : $urandom_range(2))
				offer(mk(OP_UP, 8'($urandom), 8'($urandom_range(63)), rnd_q(),
					16'($urandom), $urandom, 1'b0));
		end

		req_valid <= 1'b0;
		calm <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[gated_expert_ffn_kernel.f]
sv/gefk_pkg.sv
sv/gefk_cell.sv
sv/gefk_div.sv
sv/gefk_act.sv
sv/gated_expert_ffn_kernel.sv
test/gefk_checker.sv
test/gated_expert_ffn_kernel_tb.sv
